### rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types and constants of the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam logic [7:0] TOK_ADD = 8'h2B;
	localparam logic [7:0] TOK_SUB = 8'h2D;
	localparam logic [7:0] TOK_MUL = 8'h2A;
	localparam logic [7:0] TOK_DIV = 8'h2F;
	localparam logic [7:0] TOK_POW = 8'h5E;
	localparam logic [7:0] DIGIT_BASE = 8'd48;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_DIV = 2'd2;
	localparam logic [1:0] OP_POW = 2'd3;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
		logic       mul;
	} alu_cmd_t;

endpackage

### rtl/postfix_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core
// Evaluates a postfix expression one character per beat on a memory stack.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry one ASCII character in tdata and the end-of-
// expression mark in tlast. A character other than + - * / ^ is pushed as its
// code minus 48. An operator pops two entries, combines them and pushes the
// result, sending one step beat on m_axis. A beat with tlast also sends the
// top of stack as the final answer and empties the stack.
// The stack lives in a synchronous memory with registered read data; the
// two operands are read on consecutive cycles. Division produces one
// quotient bit per cycle and power takes a multiply and a square per
// exponent bit. One beat is worked on at a time; s_axis_tready is low
// while busy.
// Results sit in an output register; while m_axis_tready is low the block
// holds that beat and waits. Reset empties the stack and drops any pending
// result; memory contents are left as they are.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core #(
	parameter int STACK_DEPTH = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] token
	input  logic        s_axis_tlast,   // end_of_expression
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] value, [33:32] status, rest zero
	output logic        m_axis_tuser,   // result_kind
	output logic        m_axis_tlast    // last_of_run
);
	import pse_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int W  = VALUE_WIDTH;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDA  = 3'd1;
	localparam logic [2:0] S_RDB  = 3'd2;
	localparam logic [2:0] S_EXEC = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_FRD  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [W-1:0]  mem [STACK_DEPTH];
	logic [W-1:0]  rd_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [W-1:0]  wdata;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    tok_q;
	logic          last_q;
	logic [W-1:0]  a_q;
	logic [2:0]    nxt_q;     // state after the output beat drains
	logic [31:0]   out_val_q;
	logic [1:0]    out_st_q;

	alu_cmd_t      cmd;
	logic          alu_done, alu_divz;
	logic [W-1:0]  alu_res;
	logic          is_op;

	assign is_op = (tok_q == TOK_ADD) || (tok_q == TOK_SUB) || (tok_q == TOK_MUL)
	            || (tok_q == TOK_DIV) || (tok_q == TOK_POW);

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	// The left operand is held in a_q; the right operand is the read data
	// that arrives in the cycle the operation starts.
	pse_alu #(.W(W)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.a      (a_q),
		.b      (rd_q),
		.done   (alu_done),
		.res    (alu_res),
		.divz   (alu_divz)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tdata  = {6'd0, out_st_q, out_val_q};

	logic [CW-1:0] cm1, cm2;
	assign cm1 = cnt_q - 1'b1;
	assign cm2 = cnt_q - 2'd2;

	always_comb begin
		raddr = AW'(cm1);
		if (state_q == S_RDA)
			raddr = AW'(cm2);
		we    = 1'b0;
		waddr = AW'(cm2);
		wdata = alu_res;
		if (state_q == S_RDA && !is_op && cnt_q < CW'(STACK_DEPTH)) begin
			we    = 1'b1;
			waddr = AW'(cnt_q);
			wdata = W'(tok_q) - W'(DIGIT_BASE);
		end else if (state_q == S_WAIT && alu_done) begin
			we = 1'b1;
		end
		cmd.start = (state_q == S_EXEC);
		cmd.mul   = (tok_q == TOK_MUL);
		unique case (tok_q)
			TOK_SUB: cmd.op = OP_SUB;
			TOK_DIV: cmd.op = OP_DIV;
			TOK_POW: cmd.op = OP_POW;
			default: cmd.op = OP_ADD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				m_axis_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						tok_q   <= s_axis_tdata;
						last_q  <= s_axis_tlast;
						state_q <= S_RDA;
					end
				end
				S_RDA: begin
					// Push happens here; operators read the left operand.
					if (!is_op) begin
						if (cnt_q < CW'(STACK_DEPTH)) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_FIN;
						end else begin
							m_axis_tvalid <= 1'b1;
							out_val_q     <= '0;
							out_st_q      <= ST_OVER;
							m_axis_tuser  <= 1'b0;
							m_axis_tlast  <= !last_q;
							nxt_q         <= S_FIN;
							state_q       <= S_OUT;
						end
					end else if (cnt_q < CW'(2)) begin
						m_axis_tvalid <= 1'b1;
						out_val_q     <= '0;
						out_st_q      <= ST_UNDER;
						m_axis_tuser  <= 1'b0;
						m_axis_tlast  <= !last_q;
						nxt_q         <= S_FIN;
						state_q       <= S_OUT;
					end else begin
						state_q <= S_RDB;
					end
				end
				S_RDB: begin
					// Left operand arrives; the top entry is read now.
					a_q     <= rd_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (alu_done) begin
						cnt_q         <= cm1;
						m_axis_tvalid <= 1'b1;
						out_val_q     <= 32'(signed'(alu_res));
						out_st_q      <= alu_divz ? ST_DIVZ : ST_OK;
						m_axis_tuser  <= 1'b0;
						m_axis_tlast  <= !last_q;
						nxt_q         <= S_FIN;
						state_q       <= S_OUT;
					end
				end
				S_FIN: begin
					// Memory read of the top entry issued from cnt_q - 1 here.
					if (last_q)
						state_q <= S_FRD;
					else
						state_q <= S_IDLE;
				end
				S_FRD: begin
					if (!m_axis_tvalid) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tuser  <= 1'b1;
						m_axis_tlast  <= 1'b1;
						if (cnt_q == '0) begin
							out_val_q <= '0;
							out_st_q  <= ST_UNDER;
						end else begin
							out_val_q <= 32'(signed'(rd_q));
							out_st_q  <= ST_OK;
						end
						cnt_q   <= '0;
						nxt_q   <= S_IDLE;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_axis_tvalid && m_axis_tready)
						state_q <= nxt_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/pse_alu.sv
// ----------------------------------------------------------------------------
// pse_alu
// Multi-cycle arithmetic unit: add, subtract, one-step multiply, a restoring
// divider one quotient bit per cycle and a square-and-multiply power.
// ----------------------------------------------------------------------------
module pse_alu #(
	parameter int W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pse_pkg::alu_cmd_t  cmd,
	input  logic [W-1:0]       a,
	input  logic [W-1:0]       b,
	output logic               done,
	output logic [W-1:0]       res,
	output logic               divz
);
	import pse_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic [1:0]    op_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q, base_q, exp_q, rem_q, quo_q, dvs_q;
	logic          neg_q, mulph_q;

	logic [W-1:0]  mag_a, mag_b, rem_sh, rem_sub;
	logic          rem_ge;

	assign mag_a  = a[W-1] ? (~a + 1'b1) : a;
	assign mag_b  = b[W-1] ? (~b + 1'b1) : b;
	assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
	assign rem_ge = ({rem_q[W-1], rem_sh} >= {1'b0, dvs_q});
	assign rem_sub = rem_sh - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cmd.start) begin
				op_q  <= cmd.op;
				divz  <= 1'b0;
				cnt_q <= CW'(W);
				mulph_q <= 1'b0;
				if (cmd.mul) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					res    <= a * b;
				end else begin
					unique case (cmd.op)
						OP_ADD: begin
							res  <= a + b;
							done <= 1'b1;
						end
						OP_SUB: begin
							res  <= a - b;
							done <= 1'b1;
						end
						OP_DIV: begin
							if (b == '0) begin
								res  <= '0;
								divz <= 1'b1;
								done <= 1'b1;
							end else begin
								busy_q <= 1'b1;
								rem_q  <= '0;
								quo_q  <= mag_a;
								dvs_q  <= mag_b;
								neg_q  <= a[W-1] ^ b[W-1];
							end
						end
						OP_POW: begin
							if (b[W-1]) begin
								done <= 1'b1;
								if (a == W'(1))
									res <= W'(1);
								else if (a == '1)
									res <= b[0] ? '1 : W'(1);
								else
									res <= '0;
							end else begin
								busy_q <= 1'b1;
								acc_q  <= W'(1);
								base_q <= a;
								exp_q  <= b;
							end
						end
						default: ;
					endcase
				end
			end else if (busy_q) begin
				if (op_q == OP_DIV) begin
					rem_q <= rem_ge ? rem_sub : rem_sh;
					quo_q <= {quo_q[W-2:0], rem_ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						busy_q <= 1'b0;
						done   <= 1'b1;
						res    <= neg_q ? (~{quo_q[W-2:0], rem_ge} + 1'b1)
						                : {quo_q[W-2:0], rem_ge};
					end
				end else begin
					// Per exponent bit: multiply into acc, then square.
					if (exp_q == '0) begin
						busy_q <= 1'b0;
						done   <= 1'b1;
						res    <= acc_q;
					end else if (!mulph_q) begin
						if (exp_q[0])
							acc_q <= acc_q * base_q;
						mulph_q <= 1'b1;
					end else begin
						base_q  <= base_q * base_q;
						exp_q   <= exp_q >> 1;
						mulph_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives postfix expressions into the stack evaluator with random idling and
// checks every step beat and final answer against an in-bench evaluator.
// ----------------------------------------------------------------------------
module testbench;
	import pse_pkg::*;

	localparam int DEPTH = 32;

	typedef struct packed {
		logic [31:0] value;
		logic        kind;
		logic [1:0]  status;
		logic        last;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	// Shadow copy of the evaluator state.
	logic [31:0] eval_stack [DEPTH];
	int          eval_count;
	result_t     expected_results [$];
	int          errors;
	bit          idle_enable;
	bit          hold_sink;

	postfix_stack_evaluator_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [31:0] int_power(logic [31:0] base, logic [31:0] expo);
		logic [31:0] acc;
		logic [31:0] sq;
		logic [31:0] e;
		acc = 32'd1;
		sq = base;
		e = expo;
		if (expo[31]) begin
			if (base == 32'd1)
				return 32'd1;
			if (base == 32'hFFFF_FFFF)
				return expo[0] ? 32'hFFFF_FFFF : 32'd1;
			return 32'd0;
		end
		while (e != 0) begin
			if (e[0])
				acc = acc * sq;
			sq = sq * sq;
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic logic [31:0] int_divide(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic bit is_operator(logic [7:0] tok);
		return tok == TOK_ADD || tok == TOK_SUB || tok == TOK_MUL ||
			tok == TOK_DIV || tok == TOK_POW;
	endfunction

	// Appends one expected beat at the tail of the queue.
	function automatic void queue_result(result_t r);
		expected_results = {expected_results, r};
	endfunction

	// Works out the beats that one character causes and queues them.
	task automatic evaluate_token(logic [7:0] tok, logic eoe);
		result_t     r;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] v;
		logic [1:0]  st;
		int          n;
		n = 0;
		if (!is_operator(tok)) begin
			if (eval_count >= DEPTH) begin
				r = '{32'd0, 1'b0, ST_OVER, 1'b0};
				queue_result(r);
				n++;
			end else begin
				eval_stack[eval_count] = 32'(tok) - 32'(DIGIT_BASE);
				eval_count++;
			end
		end else if (eval_count < 2) begin
			r = '{32'd0, 1'b0, ST_UNDER, 1'b0};
			queue_result(r);
			n++;
		end else begin
			a = eval_stack[eval_count-2];
			b = eval_stack[eval_count-1];
			st = ST_OK;
			case (tok)
				TOK_ADD: v = a + b;
				TOK_SUB: v = a - b;
				TOK_MUL: v = a * b;
				TOK_DIV: begin
					if (b == 0) begin
						v = 0;
						st = ST_DIVZ;
					end else
						v = int_divide(a, b);
				end
				default: v = int_power(a, b);
			endcase
			eval_count -= 2;
			eval_stack[eval_count] = v;
			eval_count++;
			r = '{v, 1'b0, st, 1'b0};
			queue_result(r);
			n++;
		end
		if (eoe) begin
			if (eval_count == 0)
				r = '{32'd0, 1'b1, ST_UNDER, 1'b0};
			else
				r = '{eval_stack[eval_count-1], 1'b1, ST_OK, 1'b0};
			queue_result(r);
			eval_count = 0;
			n++;
		end
		if (n > 0)
			expected_results[$].last = 1'b1;
	endtask

	// Offers one beat, holding it until accepted, with an optional idle burst first.
	task automatic send_token(logic [7:0] tok, logic eoe);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= tok;
		s_axis_tlast  <= eoe;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		evaluate_token(tok, eoe);
	endtask

	task automatic send_digit(int d, logic eoe);
		send_token(8'(48 + d), eoe);
	endtask

	// Leaves -1 on the stack as 0 - 1 (one step beat).
	task automatic send_minus_one();
		send_digit(0, 0); send_digit(1, 0); send_token(TOK_SUB, 0);
	endtask

	task automatic random_operator(output logic [7:0] tok);
		case ($urandom_range(0, 4))
			0: tok = TOK_ADD;
			1: tok = TOK_SUB;
			2: tok = TOK_MUL;
			3: tok = TOK_DIV;
			default: tok = TOK_POW;
		endcase
	endtask

	task automatic test_operations();
		// Every operator on small operands, division by zero, negatives.
		send_digit(7, 0); send_digit(3, 0); send_token(TOK_ADD, 1);
		send_digit(2, 0); send_digit(9, 0); send_token(TOK_SUB, 1);
		send_digit(6, 0); send_digit(7, 0); send_token(TOK_MUL, 1);
		send_token(8'd41, 0); send_digit(4, 0); send_token(TOK_DIV, 1);
		send_digit(5, 0); send_digit(0, 0); send_token(TOK_DIV, 1);
		send_digit(3, 0); send_token(8'h20, 0); send_token(TOK_POW, 1);
	endtask

	task automatic test_extremes();
		// Tokens 0 and 255, empty answer, underflow, a lone push answer.
		send_token(8'h00, 0); send_token(8'hFF, 0); send_token(TOK_MUL, 1);
		send_token(TOK_ADD, 1);
		send_token(8'hFF, 1);
		send_token(TOK_SUB, 0);
		send_digit(1, 0); send_token(TOK_POW, 1);
	endtask

	task automatic test_power_cases();
		// Negative exponents with bases 1, -1 and others; zero to the zero.
		send_digit(1, 0); send_token(8'h2E, 0); send_token(TOK_POW, 1);
		send_minus_one(); send_minus_one(); send_token(TOK_POW, 1);
		send_minus_one(); send_token(8'h2E, 0); send_token(TOK_POW, 1);
		send_digit(5, 0); send_token(8'h2E, 0); send_token(TOK_POW, 1);
		send_digit(0, 0); send_digit(0, 0); send_token(TOK_POW, 1);
	endtask

	task automatic test_overflow_and_min_div();
		// Build the most negative value: 2^31 wraps; then divide by -1.
		send_digit(2, 0); send_token(8'h4F, 0); send_token(TOK_POW, 0);
		send_minus_one(); send_token(TOK_DIV, 1);
		// Fill the stack past its depth, also while the sink holds off.
		hold_sink = 1;
		for (int i = 0; i < DEPTH + 3; i++)
			send_token(8'($urandom_range(48, 57)), 0);
		hold_sink = 0;
		send_token(8'h60, 1);
	endtask

	task automatic test_random(int n_items);
		logic [7:0] tok;
		int sent;
		int depth;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				// Noise: any character, random end marker.
				send_token(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
				sent++;
			end else begin
				// Well-formed expression with random content.
				depth = 0;
				repeat ($urandom_range(1, 12)) begin
					if (depth >= 2 && $urandom_range(0, 1)) begin
						random_operator(tok);
						depth--;
					end else begin
						tok = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
							: 8'($urandom_range(48, 57));
						if (is_operator(tok))
							tok = 8'd48;
						depth++;
					end
					send_token(tok, 0);
					sent++;
				end
				while (depth >= 2) begin
					random_operator(tok);
					depth--;
					send_token(tok, depth == 1);
					sent++;
				end
				if (depth == 1) begin
					send_digit(0, 0);
					send_token(TOK_ADD, 1);
					sent += 2;
				end
			end
		end
	endtask

	// Sink readiness: random stall bursts, long hold while requested.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 1'b0;
				stall = 0;
				while (hold_sink && stall < 400) begin
					@(posedge clk);
					stall++;
				end
				m_axis_tready <= 1'b1;
				while (hold_sink)
					@(posedge clk);
			end else if (idle_enable && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Checks every accepted result beat against the oldest expectation.
	always @(posedge clk) begin
		result_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat value=%0d", $signed(m_axis_tdata[31:0]));
				errors++;
			end else begin
				r = expected_results.pop_front();
				if (m_axis_tdata[31:0] !== r.value) begin
					$error("value: expected %0d, got %0d", $signed(r.value),
						$signed(m_axis_tdata[31:0]));
					errors++;
				end
				if (m_axis_tdata[33:32] !== r.status) begin
					$error("status: expected %0d, got %0d", r.status, m_axis_tdata[33:32]);
					errors++;
				end
				if (m_axis_tuser !== r.kind) begin
					$error("result_kind: expected %0d, got %0d", r.kind, m_axis_tuser);
					errors++;
				end
				if (m_axis_tlast !== r.last) begin
					$error("last_of_run: expected %0d, got %0d", r.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int waited;
		errors = 0;
		eval_count = 0;
		idle_enable = 1;
		hold_sink = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		s_axis_tlast = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operations();
		test_extremes();
		test_power_cases();
		test_overflow_and_min_div();
		test_random(1000);
		idle_enable = 0;
		test_random(250);
		s_axis_tvalid <= 1'b0;
		waited = 0;
		while (expected_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### postfix_stack_evaluator_core.f
rtl/pse_pkg.sv
rtl/pse_alu.sv
rtl/postfix_stack_evaluator_core.sv
bench/testbench.sv
